@@ design/ssi2d_pkg.sv @@
package ssi2d_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned RatioBits     = 16;
  localparam int unsigned RatioWidth    = RatioBits + 1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_MISS     = 2'd2
  } status_e;

endpackage

@@ design/ssi2d_cross.sv @@
module ssi2d_cross #(
  parameter int unsigned CW = ssi2d_pkg::CoordWidthDef,
  parameter int unsigned RW = 2 * CW + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] ax1_i,
  input  logic signed [CW-1:0] az1_i,
  input  logic signed [CW-1:0] ax2_i,
  input  logic signed [CW-1:0] az2_i,
  input  logic signed [CW-1:0] bx1_i,
  input  logic signed [CW-1:0] bz1_i,
  input  logic signed [CW-1:0] bx2_i,
  input  logic signed [CW-1:0] bz2_i,
  output logic                 valid_o,
  output ssi2d_pkg::status_e   status_o,
  output logic [RW-1:0]        den_o,
  output logic [RW-1:0]        na_o,
  output logic [RW-1:0]        nb_o,
  output logic signed [CW:0]   dax_o,
  output logic signed [CW:0]   daz_o,
  output logic signed [CW-1:0] ax1_o,
  output logic signed [CW-1:0] az1_o
);

  localparam int unsigned PW = 2 * CW + 2;
  localparam int unsigned SW = 2 * CW + 3;

  logic signed [CW:0] dax, daz, dbx, dbz, ox, oz;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [CW:0] dax_q, daz_q;
  logic signed [CW-1:0] ax1_q, az1_q;
  logic v1_q;

  assign dax = $signed({ax2_i[CW-1], ax2_i}) - $signed({ax1_i[CW-1], ax1_i});
  assign daz = $signed({az2_i[CW-1], az2_i}) - $signed({az1_i[CW-1], az1_i});
  assign dbx = $signed({bx2_i[CW-1], bx2_i}) - $signed({bx1_i[CW-1], bx1_i});
  assign dbz = $signed({bz2_i[CW-1], bz2_i}) - $signed({bz1_i[CW-1], bz1_i});
  assign ox  = $signed({ax1_i[CW-1], ax1_i}) - $signed({bx1_i[CW-1], bx1_i});
  assign oz  = $signed({az1_i[CW-1], az1_i}) - $signed({bz1_i[CW-1], bz1_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= PW'(dbz * dax);
      p1_q  <= PW'(dbx * daz);
      p2_q  <= PW'(dbx * oz);
      p3_q  <= PW'(dbz * ox);
      p4_q  <= PW'(dax * oz);
      p5_q  <= PW'(daz * ox);
      dax_q <= dax;
      daz_q <= daz;
      ax1_q <= ax1_i;
      az1_q <= az1_i;
    end
  end

  logic signed [SW-1:0] den_s, na_s, nb_s, den_n, na_n, nb_n;
  ssi2d_pkg::status_e st_d;

  always_comb begin
    den_s = SW'(p0_q) - SW'(p1_q);
    na_s  = SW'(p2_q) - SW'(p3_q);
    nb_s  = SW'(p4_q) - SW'(p5_q);
    if (den_s < 0) begin
      den_n = -den_s;
      na_n  = -na_s;
      nb_n  = -nb_s;
    end else begin
      den_n = den_s;
      na_n  = na_s;
      nb_n  = nb_s;
    end
    if (den_s == '0) begin
      st_d = ssi2d_pkg::ST_PARALLEL;
    end else if (na_n < 0 || nb_n < 0 || na_n > den_n || nb_n > den_n) begin
      st_d = ssi2d_pkg::ST_MISS;
    end else begin
      st_d = ssi2d_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_o <= st_d;
      den_o    <= RW'($unsigned(den_n));
      na_o     <= RW'($unsigned(na_n));
      nb_o     <= RW'($unsigned(nb_n));
      dax_o    <= dax_q;
      daz_o    <= daz_q;
      ax1_o    <= ax1_q;
      az1_o    <= az1_q;
    end
  end

endmodule

@@ design/ssi2d_div_cell.sv @@
module ssi2d_div_cell #(
  parameter int unsigned CW    = ssi2d_pkg::CoordWidthDef,
  parameter int unsigned RW    = 2 * CW + 4,
  parameter bit          FIRST = 1'b0,
  parameter bit          DO_B  = 1'b1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  ssi2d_pkg::status_e                  status_i,
  input  logic [RW-1:0]                       den_i,
  input  logic [RW-1:0]                       ra_i,
  input  logic [RW-1:0]                       rb_i,
  input  logic [CW:0]                         qa_i,
  input  logic [ssi2d_pkg::RatioWidth-1:0]    qb_i,
  input  logic signed [CW:0]                  dax_i,
  input  logic signed [CW:0]                  daz_i,
  input  logic signed [CW-1:0]                ax1_i,
  input  logic signed [CW-1:0]                az1_i,
  output logic                                valid_o,
  output ssi2d_pkg::status_e                  status_o,
  output logic [RW-1:0]                       den_o,
  output logic [RW-1:0]                       ra_o,
  output logic [RW-1:0]                       rb_o,
  output logic [CW:0]                         qa_o,
  output logic [ssi2d_pkg::RatioWidth-1:0]    qb_o,
  output logic signed [CW:0]                  dax_o,
  output logic signed [CW:0]                  daz_o,
  output logic signed [CW-1:0]                ax1_o,
  output logic signed [CW-1:0]                az1_o
);

  logic [RW-1:0] sa, sb, ra_d, rb_d;
  logic ba, bb;
  logic [CW:0] qa_d;
  logic [ssi2d_pkg::RatioWidth-1:0] qb_d;

  always_comb begin
    sa   = FIRST ? ra_i : {ra_i[RW-2:0], 1'b0};
    sb   = FIRST ? rb_i : {rb_i[RW-2:0], 1'b0};
    ba   = sa >= den_i;
    bb   = sb >= den_i;
    ra_d = ba ? sa - den_i : sa;
    qa_d = {qa_i[CW-1:0], ba};
    if (DO_B) begin
      rb_d = bb ? sb - den_i : sb;
      qb_d = {qb_i[ssi2d_pkg::RatioWidth-2:0], bb};
    end else begin
      rb_d = rb_i;
      qb_d = qb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_o <= status_i;
      den_o    <= den_i;
      ra_o     <= ra_d;
      rb_o     <= rb_d;
      qa_o     <= qa_d;
      qb_o     <= qb_d;
      dax_o    <= dax_i;
      daz_o    <= daz_i;
      ax1_o    <= ax1_i;
      az1_o    <= az1_i;
    end
  end

endmodule

@@ design/ssi2d_hit.sv @@
module ssi2d_hit #(
  parameter int unsigned CW = ssi2d_pkg::CoordWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  ssi2d_pkg::status_e               status_i,
  input  logic [CW:0]                      qa_i,
  input  logic [ssi2d_pkg::RatioWidth-1:0] qb_i,
  input  logic signed [CW:0]               dax_i,
  input  logic signed [CW:0]               daz_i,
  input  logic signed [CW-1:0]             ax1_i,
  input  logic signed [CW-1:0]             az1_i,
  output logic                             valid_o,
  output ssi2d_pkg::status_e               status_o,
  output logic [ssi2d_pkg::RatioWidth-1:0] ratio_b_o,
  output logic signed [CW-1:0]             hit_x_o,
  output logic signed [CW-1:0]             hit_z_o
);

  localparam int unsigned MW = 2 * CW + 3;

  logic v_q;
  ssi2d_pkg::status_e st_q;
  logic [ssi2d_pkg::RatioWidth-1:0] qb_q;
  logic signed [MW-1:0] mx_q, mz_q, sx, sz;
  logic signed [CW-1:0] ax1_q, az1_q;
  logic hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= valid_i;
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q  <= MW'($signed({1'b0, qa_i}) * dax_i);
      mz_q  <= MW'($signed({1'b0, qa_i}) * daz_i);
      st_q  <= status_i;
      qb_q  <= qb_i;
      ax1_q <= ax1_i;
      az1_q <= az1_i;
    end
  end

  assign sx  = mx_q >>> CW;
  assign sz  = mz_q >>> CW;
  assign hit = st_q == ssi2d_pkg::ST_HIT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_o  <= st_q;
      ratio_b_o <= hit ? qb_q : '0;
      hit_x_o   <= hit ? ax1_q + sx[CW-1:0] : '0;
      hit_z_o   <= hit ? az1_q + sz[CW-1:0] : '0;
    end
  end

endmodule

@@ design/segment_segment_intersect_2d.sv @@
// Items pass the cross stage, a divider row of COORD_WIDTH + 1 cells, then the hit stage.
// Throughput: one item per cycle unless the output stalls; each divider cell gives one bit.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset is asynchronous and active low; it clears all valid flags, payload is not reset.
module segment_segment_intersect_2d #(
  parameter int unsigned COORD_WIDTH = ssi2d_pkg::CoordWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_start_z_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_a_end_z_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_start_z_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]          seg_b_end_z_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [1:0]                             status_o,
  output logic [ssi2d_pkg::RatioWidth-1:0]       ratio_b_o,
  output logic signed [COORD_WIDTH-1:0]          hit_x_o,
  output logic signed [COORD_WIDTH-1:0]          hit_z_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned RW = 2 * CW + 4;
  localparam int unsigned NC = CW + 1;

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  logic                             v   [NC+1];
  ssi2d_pkg::status_e               st  [NC+1];
  logic [RW-1:0]                    den [NC+1];
  logic [RW-1:0]                    ra  [NC+1];
  logic [RW-1:0]                    rb  [NC+1];
  logic [CW:0]                      qa  [NC+1];
  logic [ssi2d_pkg::RatioWidth-1:0] qb  [NC+1];
  logic signed [CW:0]               dax [NC+1];
  logic signed [CW:0]               daz [NC+1];
  logic signed [CW-1:0]             ax1 [NC+1];
  logic signed [CW-1:0]             az1 [NC+1];
  ssi2d_pkg::status_e               st_out;

  ssi2d_cross #(.CW(CW), .RW(RW)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i && en),
    .ax1_i(seg_a_start_x_i), .az1_i(seg_a_start_z_i),
    .ax2_i(seg_a_end_x_i),   .az2_i(seg_a_end_z_i),
    .bx1_i(seg_b_start_x_i), .bz1_i(seg_b_start_z_i),
    .bx2_i(seg_b_end_x_i),   .bz2_i(seg_b_end_z_i),
    .valid_o(v[0]), .status_o(st[0]), .den_o(den[0]), .na_o(ra[0]), .nb_o(rb[0]),
    .dax_o(dax[0]), .daz_o(daz[0]), .ax1_o(ax1[0]), .az1_o(az1[0])
  );

  assign qa[0] = '0;
  assign qb[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    ssi2d_div_cell #(
      .CW(CW), .RW(RW), .FIRST(k == 0), .DO_B(k <= ssi2d_pkg::RatioBits)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[k]), .status_i(st[k]), .den_i(den[k]), .ra_i(ra[k]), .rb_i(rb[k]),
      .qa_i(qa[k]), .qb_i(qb[k]), .dax_i(dax[k]), .daz_i(daz[k]),
      .ax1_i(ax1[k]), .az1_i(az1[k]),
      .valid_o(v[k+1]), .status_o(st[k+1]), .den_o(den[k+1]), .ra_o(ra[k+1]),
      .rb_o(rb[k+1]), .qa_o(qa[k+1]), .qb_o(qb[k+1]), .dax_o(dax[k+1]),
      .daz_o(daz[k+1]), .ax1_o(ax1[k+1]), .az1_o(az1[k+1])
    );
  end

  ssi2d_hit #(.CW(CW)) u_hit (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v[NC]), .status_i(st[NC]), .qa_i(qa[NC]), .qb_i(qb[NC]),
    .dax_i(dax[NC]), .daz_i(daz[NC]), .ax1_i(ax1[NC]), .az1_i(az1[NC]),
    .valid_o(valid_o), .status_o(st_out), .ratio_b_o(ratio_b_o),
    .hit_x_o(hit_x_o), .hit_z_o(hit_z_o)
  );

  assign status_o = st_out;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o) else $error("input stalled with empty output");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && st_out != ssi2d_pkg::ST_HIT) |->
      (ratio_b_o == '0 && hit_x_o == '0 && hit_z_o == '0))
    else $error("nonzero result fields without a hit");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ratio_b_o <= (ssi2d_pkg::RatioWidth)'(1 << ssi2d_pkg::RatioBits))
    else $error("ratio above one");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(hit_x_o) && $stable(st_out)))
    else $error("result changed while stalled");

endmodule

@@ test/tb_segment_segment_intersect_2d.sv @@
module tb_segment_segment_intersect_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = ssi2d_pkg::CoordWidthDef;
  localparam int unsigned RBW = ssi2d_pkg::RatioWidth;
  localparam int unsigned LATENCY = CW + 5;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax1, az1, ax2, az2, bx1, bz1, bx2, bz2;
  } seg_pair_t;

  typedef struct packed {
    ssi2d_pkg::status_e status;
    logic [RBW-1:0]     ratio_b;
    coord_t             hit_x;
    coord_t             hit_z;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  coord_t seg_a_start_x_i = '0, seg_a_start_z_i = '0, seg_a_end_x_i = '0, seg_a_end_z_i = '0;
  coord_t seg_b_start_x_i = '0, seg_b_start_z_i = '0, seg_b_end_x_i = '0, seg_b_end_z_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [1:0] status_o;
  logic [RBW-1:0] ratio_b_o;
  coord_t hit_x_o, hit_z_o;

  crossing_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;
  int unsigned hold_len = 0;

  segment_segment_intersect_2d uut (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .seg_a_start_x_i, .seg_a_start_z_i, .seg_a_end_x_i, .seg_a_end_z_i,
    .seg_b_start_x_i, .seg_b_start_z_i, .seg_b_end_x_i, .seg_b_end_z_i,
    .valid_o, .ready_i, .status_o, .ratio_b_o, .hit_x_o, .hit_z_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] frac_quotient(logic signed [127:0] num,
                                                logic signed [127:0] den, int bits);
    logic signed [127:0] rem;
    logic [63:0] q;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem = rem - den;
    end
    for (int i = 0; i < bits; i++) begin
      rem = rem <<< 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    logic signed [127:0] dax, daz, dbx, dbz, ox, oz, den, na, nb, qa, offx, offz;
    dax = 128'(p.ax2) - 128'(p.ax1);
    daz = 128'(p.az2) - 128'(p.az1);
    dbx = 128'(p.bx2) - 128'(p.bx1);
    dbz = 128'(p.bz2) - 128'(p.bz1);
    ox = 128'(p.ax1) - 128'(p.bx1);
    oz = 128'(p.az1) - 128'(p.bz1);
    den = dbz * dax - dbx * daz;
    na = dbx * oz - dbz * ox;
    nb = dax * oz - daz * ox;
    r = '{status: ssi2d_pkg::ST_HIT, ratio_b: '0, hit_x: '0, hit_z: '0};
    if (den == 0) begin
      r.status = ssi2d_pkg::ST_PARALLEL;
      return r;
    end
    if (den < 0) begin
      den = -den;
      na = -na;
      nb = -nb;
    end
    if (na < 0 || nb < 0 || na > den || nb > den) begin
      r.status = ssi2d_pkg::ST_MISS;
      return r;
    end
    r.ratio_b = RBW'(frac_quotient(nb, den, ssi2d_pkg::RatioBits));
    qa = {64'd0, frac_quotient(na, den, CW)};
    offx = (qa * dax) >>> CW;
    offz = (qa * daz) >>> CW;
    r.hit_x = coord_t'(128'(p.ax1) + offx);
    r.hit_z = coord_t'(128'(p.az1) + offz);
    return r;
  endfunction

  task automatic send_pair(seg_pair_t p);
    valid_i <= 1'b1;
    {seg_a_start_x_i, seg_a_start_z_i, seg_a_end_x_i, seg_a_end_z_i,
     seg_b_start_x_i, seg_b_start_z_i, seg_b_end_x_i, seg_b_end_z_i} <= p;
    do @(posedge clk_i); while (!ready_o);
    expected_q.push_back(predict_crossing(p));
  endtask

  task automatic send_gap(bit allow_gap);
    if (allow_gap && $urandom_range(0, 7) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 4000)) - 2000) <<< 16;
      2: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    coord_t cx, cz;
    int s;
    p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    s = $urandom_range(0, 9);
    if (s < 5) begin
      // Build a crossing pair: both segments straddle a shared point.
      cx = coord_t'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
      cz = coord_t'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
      p.ax1 = cx - coord_t'($urandom_range(0, 1 << 20)) + coord_t'(1 << 19);
      p.az1 = cz - coord_t'($urandom_range(0, 1 << 20)) + coord_t'(1 << 19);
      p.ax2 = 2 * cx - p.ax1;
      p.az2 = 2 * cz - p.az1;
      p.bx1 = cx - coord_t'($urandom_range(0, 1 << 20)) + coord_t'(1 << 19);
      p.bz1 = cz - coord_t'($urandom_range(0, 1 << 20)) + coord_t'(1 << 19);
      p.bx2 = 2 * cx - p.bx1;
      p.bz2 = 2 * cz - p.bz1;
      if ($urandom_range(0, 2) == 0) p.ax2 = cx;
    end else if (s == 5) begin
      p.bx2 = p.bx1 + (p.ax2 - p.ax1);
      p.bz2 = p.bz1 + (p.az2 - p.az1);
    end
    return p;
  endfunction

  task automatic drain();
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    coord_t one = 32'sh10000;
    coord_t mx = 32'sh7fffffff, mn = 32'sh80000000;
    send_pair({-one, 32'sd0, one, 32'sd0, 32'sd0, -one, 32'sd0, one});
    send_pair({32'sd0, 32'sd0, one, one, one, 32'sd0, 32'sd0, one});
    send_pair({32'sd0, 32'sd0, one, 32'sd0, 32'sd0, one, one, one});
    send_pair({32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0});
    send_pair({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_pair({32'sd0, 32'sd0, one, 32'sd0, 2 * one, -one, 2 * one, one});
    send_pair({32'sd0, 32'sd0, one, 32'sd0, one, -one, one, one});
    send_pair({32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, 32'sd0, one});
    send_pair({32'sd0, -one, 32'sd0, one, 32'sd0, 32'sd0, one, 32'sd0});
    send_pair({mn, mn, mx, mx, mn, mx, mx, mn});
    send_pair({mx, mn, mn, mx, mn, mn, mx, mx});
    send_pair({mx, mx, mx, mx, mn, mn, mn, mn});
    send_pair({mn, 32'sd0, mx, 32'sd0, 32'sd0, mn, 32'sd0, mx});
    send_pair({32'sd0, 32'sd0, 32'sd3, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd7});
    send_pair({32'sd0, 32'sd0, -one, 32'sd0, -one, -32'sd5, -one, one});
    send_pair({32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sd0,
               32'sd1, 32'sd2, 32'sh0f0f0f0f, 32'shf0f0f0f0});
    drain();
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pair(rand_pair());
      send_gap(i % 400 < 300);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_len = 200;
    hold_off = 1'b1;
    for (int i = 0; i < 120; i++) send_pair(rand_pair());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(900);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_segment_segment_intersect_2d: PASS");
    end else begin
      $display("tb_segment_segment_intersect_2d: FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) begin
        ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (phase % 512 < 128) begin
        ready_i <= 1'b1;
      end else begin
        ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: status %0d", status_o);
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status || ratio_b_o !== want.ratio_b ||
            hit_x_o !== want.hit_x || hit_z_o !== want.hit_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.status, want.ratio_b, want.hit_x, want.hit_z,
                     status_o, ratio_b_o, hit_x_o, hit_z_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_segment_segment_intersect_2d: FAIL");
      $finish;
    end
  end

endmodule
